// ----- design/tpq_pkg.sv -----
// shared types and codes for the three-class priority queue
package tpq_pkg;

	localparam int DEFAULT_DEPTH = 16;
	localparam int DEFAULT_PAYLOAD_WIDTH = 16;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_FULL  = 2'd1,
		ERR_RANGE = 2'd2
	} err_code_t;

	localparam logic [1:0] CLASS_HIGH   = 2'd0;
	localparam logic [1:0] CLASS_MIDDLE = 2'd1;
	localparam logic [1:0] CLASS_LOW    = 2'd2;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic insert;
		logic remove;
	} chain_op_t;

endpackage

// ----- design/tpq_cell.sv -----
// one queue cell: holds, loads a new entry, or takes its left or right neighbor
module tpq_cell
	import tpq_pkg::*;
#(
	parameter int PAYLOAD_WIDTH = DEFAULT_PAYLOAD_WIDTH,
	parameter int CNT_W = 5,
	parameter int INDEX = 0
) (
	input  logic                     clk,
	input  chain_op_t                op,
	input  logic [CNT_W-1:0]         at,
	input  logic [CNT_W-1:0]         pos,
	input  logic [CNT_W-1:0]         total,
	input  logic [PAYLOAD_WIDTH-1:0] new_payload,
	input  logic [1:0]               new_class,
	input  logic [PAYLOAD_WIDTH-1:0] left_payload,
	input  logic [1:0]               left_class,
	input  logic [PAYLOAD_WIDTH-1:0] right_payload,
	input  logic [1:0]               right_class,
	output logic [PAYLOAD_WIDTH-1:0] stored_payload,
	output logic [1:0]               stored_class
);

	localparam logic [CNT_W:0] IDX = (CNT_W+1)'(INDEX);

	logic [CNT_W:0] at_x, pos_x, total_x;
	logic           load_new, take_left, take_right;
	logic [PAYLOAD_WIDTH-1:0] payload_q;
	logic [1:0]               class_q;

	assign at_x    = {1'b0, at};
	assign pos_x   = {1'b0, pos};
	assign total_x = {1'b0, total};

	// insert: new entry lands at its slot, entries behind it move one back
	// remove: entries behind the gap move one forward
	assign load_new   = op.insert && (IDX == at_x);
	assign take_left  = op.insert && (IDX > at_x) && (IDX <= total_x);
	assign take_right = op.remove && (IDX >= pos_x) && ((IDX + 1'b1) < total_x);

	always_ff @(posedge clk) begin
		if (load_new) begin
			payload_q <= new_payload;
			class_q   <= new_class;
		end else if (take_left) begin
			payload_q <= left_payload;
			class_q   <= left_class;
		end else if (take_right) begin
			payload_q <= right_payload;
			class_q   <= right_class;
		end
	end

	assign stored_payload = payload_q;
	assign stored_class   = class_q;

endmodule

// ----- design/three_class_priority_queue_core.sv -----
// top level of the three-class priority queue: cell chain, counters, result register
// a result beat is registered and appears in the cycle after its item beat is accepted
// throughput: one item per cycle; every cell shifts, holds or loads in the accept cycle
// an item is held off only while the result register is full and stalled
// reset (arst_n low, asynchronous) empties the queue and clears the result valid flag;
// cell contents are not reset and are only read below the current length
module three_class_priority_queue_core
	import tpq_pkg::*;
#(
	parameter int DEPTH = DEFAULT_DEPTH,
	parameter int PAYLOAD_WIDTH = DEFAULT_PAYLOAD_WIDTH,
	localparam int CNT_W = $clog2(DEPTH + 1),
	localparam int POS_W = $clog2(DEPTH)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// item channel
	input  logic                     item_valid,
	output logic                     item_stall,
	input  logic                     opcode,
	input  logic [1:0]               entry_class,
	input  logic [PAYLOAD_WIDTH-1:0] entry_payload,
	input  logic [POS_W-1:0]         position,
	// result channel
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic                     removed_valid,
	output logic [PAYLOAD_WIDTH-1:0] removed_payload,
	output logic [1:0]               removed_class,
	output logic [1:0]               error_code,
	output logic [CNT_W-1:0]         queue_length,
	output logic [CNT_W-1:0]         high_class_end,
	output logic [CNT_W-1:0]         middle_class_end
);

	// class boundaries and length
	logic [CNT_W-1:0] hi_q, mid_q, tot_q;
	logic [CNT_W-1:0] hi_d, mid_d, tot_d;

	// result register
	logic                     res_valid_q;
	logic                     rem_valid_q;
	logic [PAYLOAD_WIDTH-1:0] rem_payload_q;
	logic [1:0]               rem_class_q;
	err_code_t                err_q;

	logic             accept;
	logic             is_insert, is_remove;
	logic             full, in_range;
	logic [1:0]       cls_eff;
	logic [CNT_W-1:0] pos_ext;
	logic [CNT_W-1:0] at;
	chain_op_t        op;
	err_code_t        err_d;

	// cell chain taps
	logic [PAYLOAD_WIDTH-1:0] cell_payload [DEPTH];
	logic [1:0]               cell_class   [DEPTH];
	logic [PAYLOAD_WIDTH-1:0] rd_payload;
	logic [1:0]               rd_class;

	// new item is taken whenever the result register will be free
	assign item_stall = res_valid_q && result_stall;
	assign accept     = item_valid && !item_stall;

	assign is_insert = (opcode == OP_INSERT);
	assign is_remove = (opcode == OP_REMOVE);

	// class three folds into the lowest class
	assign cls_eff = (entry_class > CLASS_LOW) ? CLASS_LOW : entry_class;
	assign pos_ext = CNT_W'(position);

	assign full     = (tot_q == CNT_W'(DEPTH));
	assign in_range = (pos_ext < tot_q);

	assign op.insert = accept && is_insert && !full;
	assign op.remove = accept && is_remove && in_range;

	// insert slot sits right after the last entry of the class
	always_comb begin
		case (cls_eff)
			CLASS_HIGH:   at = hi_q;
			CLASS_MIDDLE: at = mid_q;
			default:      at = tot_q;
		endcase
	end

	// boundary bookkeeping
	always_comb begin
		hi_d  = hi_q;
		mid_d = mid_q;
		tot_d = tot_q;
		if (op.insert) begin
			tot_d = tot_q + CNT_W'(1);
			if (cls_eff == CLASS_HIGH || cls_eff == CLASS_MIDDLE) begin
				mid_d = mid_q + CNT_W'(1);
			end
			if (cls_eff == CLASS_HIGH) begin
				hi_d = hi_q + CNT_W'(1);
			end
		end else if (op.remove) begin
			tot_d = tot_q - CNT_W'(1);
			if (pos_ext < mid_q) begin
				mid_d = mid_q - CNT_W'(1);
			end
			if (pos_ext < hi_q) begin
				hi_d = hi_q - CNT_W'(1);
			end
		end
	end

	always_comb begin
		err_d = ERR_NONE;
		if (is_insert && full) begin
			err_d = ERR_FULL;
		end else if (is_remove && !in_range) begin
			err_d = ERR_RANGE;
		end
	end

	// the chain: each cell sees its two neighbors, ends tied off
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [PAYLOAD_WIDTH-1:0] left_p, right_p;
		logic [1:0]               left_c, right_c;

		if (i == 0) begin : g_head
			assign left_p = '0;
			assign left_c = '0;
		end else begin : g_mid_l
			assign left_p = cell_payload[i-1];
			assign left_c = cell_class[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_p = '0;
			assign right_c = '0;
		end else begin : g_mid_r
			assign right_p = cell_payload[i+1];
			assign right_c = cell_class[i+1];
		end

		tpq_cell #(
			.PAYLOAD_WIDTH (PAYLOAD_WIDTH),
			.CNT_W         (CNT_W),
			.INDEX         (i)
		) u_cell (
			.clk            (clk),
			.op             (op),
			.at             (at),
			.pos            (pos_ext),
			.total          (tot_q),
			.new_payload    (entry_payload),
			.new_class      (cls_eff),
			.left_payload   (left_p),
			.left_class     (left_c),
			.right_payload  (right_p),
			.right_class    (right_c),
			.stored_payload (cell_payload[i]),
			.stored_class   (cell_class[i])
		);
	end

	// pick the entry under the removal position, zero when nothing matches
	always_comb begin
		rd_payload = '0;
		rd_class   = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (pos_ext == CNT_W'(i)) begin
				rd_payload = rd_payload | cell_payload[i];
				rd_class   = rd_class | cell_class[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_q        <= '0;
			mid_q       <= '0;
			tot_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			hi_q  <= hi_d;
			mid_q <= mid_d;
			tot_q <= tot_d;
			if (accept) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result beat payload, loaded with each accepted item
	always_ff @(posedge clk) begin
		if (accept) begin
			rem_valid_q   <= op.remove;
			rem_payload_q <= op.remove ? rd_payload : '0;
			rem_class_q   <= op.remove ? rd_class : '0;
			err_q         <= err_d;
		end
	end

	assign result_valid     = res_valid_q;
	assign removed_valid    = rem_valid_q;
	assign removed_payload  = rem_payload_q;
	assign removed_class    = rem_class_q;
	assign error_code       = err_q;
	// boundaries after the item are what the registers now hold
	assign queue_length     = tot_q;
	assign high_class_end   = hi_q;
	assign middle_class_end = mid_q;

endmodule
